[src/tthd_pkg.sv]
// teletext hamming decoder package: operation codes, parity masks and
// the 8/4 correction table of tthd_h84_dec; no dependencies
`default_nettype none

package tthd_pkg;

  typedef enum logic [1:0] {
    REQ_H84_SINGLE   = 2'd0,
    REQ_H84_PAIR_LO  = 2'd1,
    REQ_H84_PAIR_HI  = 2'd2,
    REQ_H2418_TRIPLE = 2'd3
  } req_type_t;

  // hamming 8/4 test masks
  localparam logic [7:0] H84_MASK_A = 8'hA3;
  localparam logic [7:0] H84_MASK_B = 8'h8E;
  localparam logic [7:0] H84_MASK_C = 8'h3A;

  // hamming 24/18 test masks, per byte
  localparam logic [7:0] H2418_MASK_A  = 8'h55;
  localparam logic [7:0] H2418_MASK_B  = 8'h66;
  localparam logic [7:0] H2418_MASK_C  = 8'h78;
  localparam logic [7:0] H2418_MASK_HI = 8'h80;
  localparam logic [7:0] H2418_MASK_LO = 8'h7F;

  // highest syndrome that names a real bit position
  localparam logic [4:0] H2418_MAX_SYN = 5'd24;

  localparam int unsigned DATA_W = 18;

  typedef struct packed {
    logic [3:0] nib;
    logic       bad;
  } h84_res_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              bad;
  } h2418_res_t;

  // data-bit flip for each 8/4 syndrome
  function automatic logic [3:0] h84_fix(input logic [2:0] syn);
    logic [3:0] f;
    case (syn)
      3'd3:    f = 4'd8;
      3'd5:    f = 4'd4;
      3'd6:    f = 4'd2;
      3'd7:    f = 4'd1;
      default: f = 4'd0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

[src/teletext_hamming_decoder.sv]
// teletext hamming 8/4 and 24/18 decoder, top level
// depends on tthd_pkg, tthd_h84_dec and tthd_h2418_dec
//
// usage:
//   in_*  : one request per handshake, operation code on in_tuser, up to
//           three received bytes on in_tdata in transmission order
//   out_* : one result per request, decoded data on out_tdata, the
//           uncorrectable flag on out_tuser
//   an accepted request goes into the input register, then through decode
//   logic into the output register that drives out_tvalid
//   throughput is one request per clock while out_tready is high; the two
//   register stages form a short pipeline, ready chaining back from out_tready
//   when the receiver stalls, the output register holds its result and the
//   input register holds the next request, so two requests are buffered
//   before in_tready drops
//   rst_n (synchronous, active low) empties both stages; no other state
//   exists, the decode itself keeps no history between requests
//   nibbles that cannot be corrected read 15, uncorrectable triplets read 0
`default_nettype none

module teletext_hamming_decoder
  import tthd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // byte0 [7:0], byte1 [15:8], byte2 [23:16]
  input  wire logic [1:0]  in_tuser,   // req_type [1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // decoded [17:0], zero fill [23:18]
  output logic [0:0]       out_tuser   // uncorrectable [0]
);

  // input stage
  logic        in_vld_r;
  logic        in_vld_nxt;
  logic [23:0] in_bytes_r;
  logic [1:0]  in_type_r;

  // output stage
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic [DATA_W-1:0] out_data_r;
  logic              out_bad_r;

  logic out_load;
  logic in_load;

  h84_res_t   res0;
  h84_res_t   res1;
  h2418_res_t res_t;

  logic [DATA_W-1:0] dec_data;
  logic              dec_bad;

  // output register can take a result when empty or being drained
  assign out_load  = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || !out_vld_r || out_tready;
  assign in_load   = in_tvalid && in_tready;

  tthd_h84_dec u_h84_0 (
    .code_byte (in_bytes_r[7:0]),
    .res       (res0)
  );

  tthd_h84_dec u_h84_1 (
    .code_byte (in_bytes_r[15:8]),
    .res       (res1)
  );

  tthd_h2418_dec u_h2418 (
    .b0  (in_bytes_r[7:0]),
    .b1  (in_bytes_r[15:8]),
    .b2  (in_bytes_r[23:16]),
    .res (res_t)
  );

  // pick the result for the operation code
  always_comb begin
    case (req_type_t'(in_type_r))
      REQ_H84_SINGLE: begin
        dec_data = {14'd0, res0.nib};
        dec_bad  = res0.bad;
      end
      REQ_H84_PAIR_LO: begin
        dec_data = {10'd0, res1.nib, res0.nib};
        dec_bad  = res0.bad | res1.bad;
      end
      REQ_H84_PAIR_HI: begin
        dec_data = {10'd0, res0.nib, res1.nib};
        dec_bad  = res0.bad | res1.bad;
      end
      default: begin
        dec_data = res_t.data;
        dec_bad  = res_t.bad;
      end
    endcase
  end

  always_comb begin
    in_vld_nxt  = in_load ? 1'b1 : (out_load ? 1'b0 : in_vld_r);
    out_vld_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_load) begin
      in_bytes_r <= in_tdata;
      in_type_r  <= in_tuser;
    end
    if (out_load) begin
      out_data_r <= dec_data;
      out_bad_r  <= dec_bad;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = {6'd0, out_data_r};
  assign out_tuser[0] = out_bad_r;

endmodule

`default_nettype wire

[src/tthd_h84_dec.sv]
// hamming 8/4 byte decoder, purely combinational
// depends on tthd_pkg
`default_nettype none

module tthd_h84_dec
  import tthd_pkg::*;
(
  input  wire logic [7:0] code_byte,
  output h84_res_t        res
);

  logic [2:0] syn;
  logic [3:0] raw;

  always_comb begin
    // each test checks for odd parity
    syn[0] = ~(^(code_byte & H84_MASK_A));
    syn[1] = ~(^(code_byte & H84_MASK_B));
    syn[2] = ~(^(code_byte & H84_MASK_C));
    raw    = {code_byte[7], code_byte[5], code_byte[3], code_byte[1]};
    if ((syn != 3'd0) && (^code_byte)) begin
      res.nib = 4'hF;
      res.bad = 1'b1;
    end else begin
      res.nib = raw ^ h84_fix(syn);
      res.bad = 1'b0;
    end
  end

endmodule

`default_nettype wire

[src/tthd_h2418_dec.sv]
// hamming 24/18 triplet decoder, purely combinational
// depends on tthd_pkg
`default_nettype none

module tthd_h2418_dec
  import tthd_pkg::*;
(
  input  wire logic [7:0] b0,
  input  wire logic [7:0] b1,
  input  wire logic [7:0] b2,
  output h2418_res_t      res
);

  logic [4:0]  syn;
  logic        par_all;
  logic [23:0] word;
  logic [23:0] flip;
  logic [23:0] fixed;

  always_comb begin
    syn[0] = ~(^(b0 & H2418_MASK_A) ^ ^(b1 & H2418_MASK_A) ^ ^(b2 & H2418_MASK_A));
    syn[1] = ~(^(b0 & H2418_MASK_B) ^ ^(b1 & H2418_MASK_B) ^ ^(b2 & H2418_MASK_B));
    syn[2] = ~(^(b0 & H2418_MASK_C) ^ ^(b1 & H2418_MASK_C) ^ ^(b2 & H2418_MASK_C));
    syn[3] = ~(^(b0 & H2418_MASK_HI) ^ ^(b1 & H2418_MASK_LO));
    syn[4] = ~(^(b1 & H2418_MASK_HI) ^ ^(b2 & H2418_MASK_LO));
    par_all = ^{b0, b1, b2};
    word    = {b2, b1, b0};
    flip    = (syn != 5'd0) ? (24'd1 << (syn - 5'd1)) : 24'd0;
    fixed   = word ^ flip;
    // double error, or syndrome past the last bit position
    if (((syn != 5'd0) && par_all) || (syn > H2418_MAX_SYN)) begin
      res.data = '0;
      res.bad  = 1'b1;
    end else begin
      res.data = {fixed[22:16], fixed[14:8], fixed[6:4], fixed[2]};
      res.bad  = 1'b0;
    end
  end

endmodule

`default_nettype wire

[src/tthd_checker.sv]
// port-level checks for the teletext hamming decoder, bound to the top level
// depends on teletext_hamming_decoder
`default_nettype none

module tthd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // with an empty output stage the input can never be blocked
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  // with a free-running receiver, an accepted request reaches out_tvalid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && out_tready) ##1 out_tready |=> out_tvalid)
    else $error("result missing two cycles after request");

  // upper fill bits of the result are zero
  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:18] == 6'd0))
    else $error("nonzero fill bits in result");

endmodule

bind teletext_hamming_decoder tthd_checker u_tthd_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for teletext_hamming_decoder: 8/4 and 24/18 decodes
// checked against an in-bench predictor, random idling on both stream sides
// depends on tthd_pkg and the decoder rtl only
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tthd_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1830;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned MAX_REPORTS     = 10;

  // one request as sent on the input channel
  typedef struct packed {
    req_type_t  op;
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
  } request_t;

  // one decode result as expected on the output channel
  typedef struct packed {
    logic [17:0] data;
    logic        bad;
  } decode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = 24'd0;
  logic [1:0]  in_tuser = REQ_H84_SINGLE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;

  request_t    request_q[$];    // requests not yet presented
  decode_t     decode_q[$];     // decodes predicted for accepted requests
  logic        req_taken = 1'b0;
  int unsigned taken_count = 0;
  int unsigned result_count = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned op_count[4] = '{default: 0};
  int unsigned flagged_count = 0;
  logic        no_idle;

  // a stretch of requests with both sides streaming flat out
  assign no_idle = (taken_count >= 700) && (taken_count < 1000);

  // ---------------------------------------------------------------- predictor

  // 8/4 byte to {bad, nibble}; every test checks for odd parity
  function automatic logic [4:0] h84_decode(input logic [7:0] b);
    logic [2:0] syn;
    logic [3:0] fix;
    syn = {~^(b & 8'h3A), ~^(b & 8'h8E), ~^(b & 8'hA3)};
    // a failed test with odd overall parity means two bits went wrong
    if (syn != 3'd0 && ^b) return {1'b1, 4'hF};
    // only syndromes that name a data bit flip anything
    case (syn)
      3'd3:    fix = 4'h8;
      3'd5:    fix = 4'h4;
      3'd6:    fix = 4'h2;
      3'd7:    fix = 4'h1;
      default: fix = 4'h0;
    endcase
    return {1'b0, {b[7], b[5], b[3], b[1]} ^ fix};
  endfunction

  // 24/18 triplet to {bad, 18 data bits}
  function automatic logic [18:0] h2418_decode(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2);
    logic [4:0]  syn;
    logic [23:0] w;
    syn[0] = ~^{b0 & 8'h55, b1 & 8'h55, b2 & 8'h55};
    syn[1] = ~^{b0 & 8'h66, b1 & 8'h66, b2 & 8'h66};
    syn[2] = ~^{b0 & 8'h78, b1 & 8'h78, b2 & 8'h78};
    syn[3] = ~^{b0 & 8'h80, b1 & 8'h7F};
    syn[4] = ~^{b1 & 8'h80, b2 & 8'h7F};
    if (syn != 5'd0 && ^{b0, b1, b2}) return {1'b1, 18'd0};
    // syndrome past the last bit position cannot be a single error
    if (syn > 5'd24) return {1'b1, 18'd0};
    w = {b2, b1, b0};
    if (syn != 5'd0) w = w ^ (24'd1 << (syn - 5'd1));
    return {1'b0, w[22:16], w[14:8], w[6:4], w[2]};
  endfunction

  function automatic decode_t decode_request(input request_t r);
    decode_t    res;
    logic [4:0] lo_nib;
    logic [4:0] hi_nib;
    logic [18:0] tri_res;
    res = '0;
    lo_nib = h84_decode(r.byte0);
    hi_nib = h84_decode(r.byte1);
    case (r.op)
      REQ_H84_SINGLE: begin
        res.data = {14'd0, lo_nib[3:0]};
        res.bad  = lo_nib[4];
      end
      REQ_H84_PAIR_LO: begin
        res.data = {10'd0, hi_nib[3:0], lo_nib[3:0]};
        res.bad  = lo_nib[4] | hi_nib[4];
      end
      REQ_H84_PAIR_HI: begin
        res.data = {10'd0, lo_nib[3:0], hi_nib[3:0]};
        res.bad  = lo_nib[4] | hi_nib[4];
      end
      default: begin
        tri_res  = h2418_decode(r.byte0, r.byte1, r.byte2);
        res.data = tri_res[17:0];
        res.bad  = tri_res[18];
      end
    endcase
    return res;
  endfunction

  // ------------------------------------------------------------ stimulus help

  function automatic logic [7:0] h84_encode(input logic [3:0] nib);
    logic [7:0] b;
    b = {nib[3], 1'b0, nib[2], 1'b0, nib[1], 1'b0, nib[0], 1'b0};
    b[0] = ~^(b & 8'hA3);
    b[2] = ~^(b & 8'h8E);
    b[4] = ~^(b & 8'h3A);
    b[6] = ~^b;
    return b;
  endfunction

  // positions 1..23 xor to all ones in a clean triplet, position 24 sets parity
  function automatic logic [23:0] h2418_encode(input logic [17:0] d);
    logic [23:0] w;
    logic [4:0]  x;
    int          p;
    w = 24'd0;
    w[2]     = d[0];
    w[6:4]   = d[3:1];
    w[14:8]  = d[10:4];
    w[22:16] = d[17:11];
    x = 5'd0;
    for (p = 1; p <= 23; p++) if (w[p-1]) x = x ^ p[4:0];
    x = x ^ 5'h1F;
    w[0]  = x[0];
    w[1]  = x[1];
    w[3]  = x[2];
    w[7]  = x[3];
    w[15] = x[4];
    w[23] = ~^w[22:0];
    return w;
  endfunction

  // flips count distinct bits among the lowest width bits
  function automatic logic [23:0] add_errors(input logic [23:0] w, input int width,
                                             input int count);
    logic [23:0] m;
    int          k;
    int          idx;
    m = 24'd0;
    for (k = 0; k < count; k++) begin
      do idx = $urandom_range(width - 1); while (m[idx]);
      m[idx] = 1'b1;
    end
    return w ^ m;
  endfunction

  function automatic int error_count_pick();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 75) return 1;
    if (r < 92) return 2;
    return 3;
  endfunction

  // mostly codewords with a few flipped bits, some raw noise
  function automatic logic [7:0] random_h84_byte();
    logic [23:0] w;
    if ($urandom_range(9) == 0) return 8'($urandom);
    w = add_errors({16'd0, h84_encode(4'($urandom))}, 8, error_count_pick());
    return w[7:0];
  endfunction

  function automatic logic [23:0] random_triplet();
    if ($urandom_range(9) == 0) return 24'($urandom);
    return add_errors(h2418_encode(18'($urandom)), 24, error_count_pick());
  endfunction

  task automatic queue_request(input req_type_t op, input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2);
    request_t r;
    r.op    = op;
    r.byte0 = b0;
    r.byte1 = b1;
    r.byte2 = b2;
    request_q.push_back(r);
  endtask

  task automatic queue_triplet(input logic [23:0] w);
    queue_request(REQ_H2418_TRIPLE, w[7:0], w[15:8], w[23:16]);
  endtask

  // ----------------------------------------------------------------- the block

  teletext_hamming_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // ------------------------------------------------------------------- driver

  // a new request goes out once the previous one was taken, or after a gap
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || req_taken) begin
        if (request_q.size() != 0 && (no_idle || $urandom_range(99) >= 33)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {request_q[0].byte2, request_q[0].byte1, request_q[0].byte0};
          in_tuser  <= request_q[0].op;
          void'(request_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= no_idle || ($urandom_range(99) >= 33);
    end
  end

  // ------------------------------------------------------------------ monitor

  always @(posedge clk) begin
    decode_t exp_res;
    request_t r;
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_tvalid && in_tready;

      // result side: compare with the oldest outstanding decode
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (decode_q.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: result with no request outstanding: data %05h flag %0d",
                   $time, out_tdata[17:0], out_tuser[0]);
        end else begin
          exp_res = decode_q.pop_front();
          if (out_tdata[17:0] !== exp_res.data || out_tuser[0] !== exp_res.bad) begin
            if (fail_count < MAX_REPORTS)
              $display("%0t: mismatch: decoded %05h exp %05h, uncorrectable %0d exp %0d",
                       $time, out_tdata[17:0], exp_res.data, out_tuser[0], exp_res.bad);
            fail_count <= fail_count + 1;
          end
        end
      end

      // request side: predict the decode at the moment it is accepted
      if (in_tvalid && in_tready) begin
        r.op    = req_type_t'(in_tuser);
        r.byte0 = in_tdata[7:0];
        r.byte1 = in_tdata[15:8];
        r.byte2 = in_tdata[23:16];
        exp_res = decode_request(r);
        decode_q.push_back(exp_res);
        taken_count <= taken_count + 1;
        op_count[in_tuser] <= op_count[in_tuser] + 1;
        if (exp_res.bad) flagged_count <= flagged_count + 1;
      end
    end
  end

  // ----------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d decodes outstanding",
                 $time, quiet_cycles, decode_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ----------------------------------------------------------------- sequence

  initial begin
    int unsigned i;
    int          sel;
    logic [23:0] t;

    // single 8/4: extremes, clean codewords, data and protection bit errors, a double
    queue_request(REQ_H84_SINGLE, 8'h00, 8'($urandom), 8'($urandom));
    queue_request(REQ_H84_SINGLE, 8'hFF, 8'($urandom), 8'($urandom));
    queue_request(REQ_H84_SINGLE, h84_encode(4'h0), 8'hFF, 8'hFF);
    queue_request(REQ_H84_SINGLE, h84_encode(4'hF), 8'h00, 8'h00);
    queue_request(REQ_H84_SINGLE, h84_encode(4'h5) ^ 8'h08, 8'($urandom), 8'($urandom));
    queue_request(REQ_H84_SINGLE, h84_encode(4'hA) ^ 8'h01, 8'($urandom), 8'($urandom));
    queue_request(REQ_H84_SINGLE, h84_encode(4'h9) ^ 8'h40, 8'($urandom), 8'($urandom));
    queue_request(REQ_H84_SINGLE, h84_encode(4'h6) ^ 8'h06, 8'($urandom), 8'($urandom));

    // pairs: clean, a corrected single error, and one byte beyond repair while the other still decodes
    queue_request(REQ_H84_PAIR_LO, h84_encode(4'h3), h84_encode(4'hC), 8'($urandom));
    queue_request(REQ_H84_PAIR_LO, h84_encode(4'h7), h84_encode(4'h2) ^ 8'h81, 8'($urandom));
    queue_request(REQ_H84_PAIR_HI, h84_encode(4'hE) ^ 8'h20, h84_encode(4'h1), 8'($urandom));
    queue_request(REQ_H84_PAIR_HI, h84_encode(4'h4) ^ 8'h0A, h84_encode(4'hB), 8'($urandom));

    // triplets: extremes, single errors, protection bit 24 alone, double error, triple
    // errors whose syndrome lands past 24 or on 24, and raw all-zero and all-ones words
    queue_triplet(h2418_encode(18'h00000));
    queue_triplet(h2418_encode(18'h3FFFF));
    queue_triplet(h2418_encode(18'h2AAAA) ^ 24'h000400);
    queue_triplet(h2418_encode(18'h15555) ^ 24'h800000);
    queue_triplet(h2418_encode(18'h12345) ^ 24'h000001);
    queue_triplet(h2418_encode(18'h3C3C3) ^ 24'h002010);
    queue_triplet(h2418_encode(18'h0F0F0) ^ 24'h008081);
    queue_triplet(h2418_encode(18'h1E1E1) ^ 24'h808080);
    queue_triplet(h2418_encode(18'h3FFFF) ^ 24'h400000);
    queue_triplet(24'h000000);
    queue_triplet(24'hFFFFFF);

    // random part
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      sel = $urandom_range(3);
      if (sel == 3) begin
        queue_triplet(random_triplet());
      end else begin
        t = {8'($urandom), random_h84_byte(), random_h84_byte()};
        queue_request(req_type_t'(sel), t[7:0], t[15:8], t[23:16]);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait until every request is in and every decode has come back
    while (request_q.size() != 0 || in_tvalid || decode_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (decode_q.size() != 0) begin
      $display("%0d decodes never arrived", decode_q.size());
      fail_count = fail_count + decode_q.size();
    end

    $display("decoded %0d requests: %0d single, %0d pair low, %0d pair high, %0d triplet",
             taken_count, op_count[REQ_H84_SINGLE], op_count[REQ_H84_PAIR_LO],
             op_count[REQ_H84_PAIR_HI], op_count[REQ_H2418_TRIPLE]);
    $display("%0d results checked, %0d flagged uncorrectable, %0d failures",
             result_count, flagged_count, fail_count);

    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
